### sv/mpm_pkg.sv
`timescale 1ns / 1ps

package mpm_pkg;

  // Fixed field widths of the command and result channels.
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned EXP_W     = 64;
  localparam int unsigned POS_W     = 4;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned DIM_W     = 5;
  localparam int unsigned CFG_IDX_W = 2;

  // Default largest matrix size held in the stores.
  localparam int unsigned MAX_DIM_DEF = 16;

  // Dimension in use after reset.
  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(16);

  // Command codes.
  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_POWER = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DIM  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_CIRC = CFG_IDX_W'(1);

endpackage

### sv/mpm_ram.sv
`timescale 1ns / 1ps

module mpm_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8,
  parameter int unsigned DW    = 32
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] ra_addr_i,
  input  logic [AW-1:0] rb_addr_i,
  output logic [DW-1:0] ra_data_o,
  output logic [DW-1:0] rb_data_o
);

  logic [DW-1:0] mem [DEPTH];

  // One write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Two read ports with registered data.
  always_ff @(posedge clk_i) begin
    ra_data_o <= mem[ra_addr_i];
    rb_data_o <= mem[rb_addr_i];
  end

endmodule

### sv/mpm_engine.sv
`timescale 1ns / 1ps

module mpm_engine
  import mpm_pkg::*;
#(
  parameter int unsigned MAX_DIM = MAX_DIM_DEF,
  parameter int unsigned CELLS   = MAX_DIM * MAX_DIM,
  parameter int unsigned AW      = $clog2(CELLS)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [EXP_W-1:0]  exp_i,
  input  logic [DIM_W-1:0]  dim_i,
  input  logic              circ_i,
  input  logic              host_we_i,
  input  logic [AW-1:0]     host_waddr_i,
  input  logic [DATA_W-1:0] host_wdata_i,
  input  logic [AW-1:0]     host_raddr_i,
  output logic [DATA_W-1:0] host_rdata_o,
  output logic              idle_o
);

  localparam int unsigned IW = $clog2(MAX_DIM);
  localparam int unsigned NW = $clog2(MAX_DIM + 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INIT,
    ST_CHECK,
    ST_MUL,
    ST_COPY
  } state_e;

  state_e            state_q, state_d;
  logic [IW-1:0]     i_q, i_d, j_q, j_d, k_q, k_d;
  logic [EXP_W-1:0]  e_q, e_d;
  logic [NW-1:0]     n_q, n_d;
  logic              circ_q, circ_d;
  logic              phase_q, phase_d;
  logic              mode_res_q, mode_res_d;
  logic              issue_done_q, issue_done_d;
  logic              s1_valid_q, s1_valid_d;
  logic              s1_first_q, s1_first_d;
  logic              s1_last_q, s1_last_d;
  logic              s1_inblk_q, s1_inblk_d;
  logic              s1_diag_q, s1_diag_d;
  logic [AW-1:0]     s1_waddr_q, s1_waddr_d;
  logic              s2_valid_q, s2_first_q, s2_last_q;
  logic [AW-1:0]     s2_waddr_q;
  logic [DATA_W-1:0] prod_q, acc_q, acc_sum;

  // Memory port signals.
  logic              src_we, res_we, sq_we, tmp_we;
  logic [AW-1:0]     src_wa, res_wa, sq_wa, tmp_wa;
  logic [DATA_W-1:0] src_wd, res_wd, sq_wd, tmp_wd;
  logic [AW-1:0]     src_ra, res_ra, sq_ra, sq_rb, tmp_ra;
  logic [DATA_W-1:0] src_rd, res_rd, sq_rda, sq_rdb, tmp_rd;
  logic [DATA_W-1:0] lhs_data;
  logic [AW-1:0]     lhs_addr, rhs_addr, cur_addr;
  logic              cur_inblk, sweep_last, k_last, j_last, i_last;
  logic [NW:0]       rot;

  function automatic logic [AW-1:0] cell_addr(input logic [IW-1:0] r, input logic [IW-1:0] c);
    cell_addr = AW'(r) * AW'(MAX_DIM) + AW'(c);
  endfunction

  // Position helpers for the counters.
  assign cur_addr   = cell_addr(i_q, j_q);
  assign cur_inblk  = (int'(i_q) < int'(n_q)) && (int'(j_q) < int'(n_q));
  assign sweep_last = (int'(i_q) == MAX_DIM - 1) && (int'(j_q) == MAX_DIM - 1);
  assign k_last     = int'(k_q) == int'(n_q) - 1;
  assign j_last     = int'(j_q) == int'(n_q) - 1;
  assign i_last     = int'(i_q) == int'(n_q) - 1;
  assign lhs_addr   = cell_addr(circ_q ? '0 : i_q, k_q);
  assign rhs_addr   = cell_addr(k_q, j_q);
  assign lhs_data   = mode_res_q ? res_rd : sq_rda;
  assign acc_sum    = (s2_first_q ? '0 : acc_q) + prod_q;

  // Column of row zero that lands at (i, j) after rotating right by i.
  always_comb begin
    if (j_q >= i_q) begin
      rot = (NW+1)'(j_q) - (NW+1)'(i_q);
    end else begin
      rot = (NW+1)'(j_q) + (NW+1)'(n_q) - (NW+1)'(i_q);
    end
  end

  // Memory port selection.
  always_comb begin
    src_we = host_we_i;
    src_wa = host_waddr_i;
    src_wd = host_wdata_i;
    src_ra = cur_addr;
    res_we = 1'b0;
    res_wa = s1_waddr_q;
    res_wd = '0;
    res_ra = (state_q == ST_IDLE) ? host_raddr_i : lhs_addr;
    sq_we  = 1'b0;
    sq_wa  = s1_waddr_q;
    sq_wd  = s1_inblk_q ? src_rd : '0;
    sq_ra  = lhs_addr;
    sq_rb  = rhs_addr;
    tmp_we = s2_valid_q && s2_last_q;
    tmp_wa = s2_waddr_q;
    tmp_wd = acc_sum;
    tmp_ra = '0;
    if (cur_inblk) begin
      tmp_ra = circ_q ? cell_addr('0, IW'(rot)) : cur_addr;
    end
    case (state_q)
      ST_CLEAR: begin
        src_we = 1'b1;
        src_wa = cur_addr;
        src_wd = '0;
        res_we = 1'b1;
        res_wa = cur_addr;
      end
      ST_INIT: begin
        res_we = s1_valid_q;
        res_wd = DATA_W'(s1_inblk_q && s1_diag_q);
        sq_we  = s1_valid_q;
      end
      ST_COPY: begin
        res_we = s1_valid_q && mode_res_q;
        res_wd = s1_inblk_q ? tmp_rd : '0;
        sq_we  = s1_valid_q && !mode_res_q;
        sq_wd  = s1_inblk_q ? tmp_rd : '0;
      end
      default: begin
      end
    endcase
  end

  // Sequencer: clearing pass, setup, square-and-multiply steps and copy-back.
  always_comb begin
    state_d      = state_q;
    i_d          = i_q;
    j_d          = j_q;
    k_d          = k_q;
    e_d          = e_q;
    n_d          = n_q;
    circ_d       = circ_q;
    phase_d      = phase_q;
    mode_res_d   = mode_res_q;
    issue_done_d = issue_done_q;
    s1_valid_d   = 1'b0;
    s1_first_d   = k_q == '0;
    s1_last_d    = k_last;
    s1_inblk_d   = cur_inblk;
    s1_diag_d    = i_q == j_q;
    s1_waddr_d   = cur_addr;
    case (state_q)
      ST_CLEAR: begin
        j_d = j_q + 1'b1;
        if (int'(j_q) == MAX_DIM - 1) begin
          j_d = '0;
          i_d = i_q + 1'b1;
        end
        if (sweep_last) begin
          i_d     = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          if (dim_i == '0) begin
            n_d = NW'(1);
          end else if (int'(dim_i) > MAX_DIM) begin
            n_d = NW'(MAX_DIM);
          end else begin
            n_d = NW'(dim_i);
          end
          circ_d       = circ_i;
          e_d          = exp_i;
          phase_d      = 1'b0;
          i_d          = '0;
          j_d          = '0;
          issue_done_d = 1'b0;
          state_d      = ST_INIT;
        end
      end
      ST_INIT, ST_COPY: begin
        if (!issue_done_q) begin
          s1_valid_d = 1'b1;
          j_d        = j_q + 1'b1;
          if (int'(j_q) == MAX_DIM - 1) begin
            j_d = '0;
            i_d = i_q + 1'b1;
          end
          if (sweep_last) begin
            i_d          = '0;
            issue_done_d = 1'b1;
          end
        end else if (!s1_valid_q) begin
          issue_done_d = 1'b0;
          state_d      = ST_CHECK;
        end
      end
      ST_CHECK: begin
        i_d = '0;
        j_d = '0;
        k_d = '0;
        if (e_q == '0) begin
          state_d = ST_IDLE;
        end else if (!phase_q) begin
          phase_d = 1'b1;
          if (e_q[0]) begin
            mode_res_d = 1'b1;
            state_d    = ST_MUL;
          end
        end else begin
          phase_d = 1'b0;
          e_d     = e_q >> 1;
          if ((e_q >> 1) != '0) begin
            mode_res_d = 1'b0;
            state_d    = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        if (!issue_done_q) begin
          s1_valid_d = 1'b1;
          k_d        = k_q + 1'b1;
          if (k_last) begin
            k_d = '0;
            j_d = j_q + 1'b1;
            if (j_last) begin
              j_d = '0;
              if (circ_q || i_last) begin
                i_d          = '0;
                issue_done_d = 1'b1;
              end else begin
                i_d = i_q + 1'b1;
              end
            end
          end
        end else if (!s1_valid_q && !s2_valid_q) begin
          issue_done_d = 1'b0;
          state_d      = ST_COPY;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      i_q          <= '0;
      j_q          <= '0;
      k_q          <= '0;
      e_q          <= '0;
      n_q          <= '0;
      circ_q       <= 1'b0;
      phase_q      <= 1'b0;
      mode_res_q   <= 1'b0;
      issue_done_q <= 1'b0;
      s1_valid_q   <= 1'b0;
      s1_first_q   <= 1'b0;
      s1_last_q    <= 1'b0;
      s1_inblk_q   <= 1'b0;
      s1_diag_q    <= 1'b0;
      s1_waddr_q   <= '0;
      s2_valid_q   <= 1'b0;
      s2_first_q   <= 1'b0;
      s2_last_q    <= 1'b0;
      s2_waddr_q   <= '0;
    end else begin
      state_q      <= state_d;
      i_q          <= i_d;
      j_q          <= j_d;
      k_q          <= k_d;
      e_q          <= e_d;
      n_q          <= n_d;
      circ_q       <= circ_d;
      phase_q      <= phase_d;
      mode_res_q   <= mode_res_d;
      issue_done_q <= issue_done_d;
      s1_valid_q   <= s1_valid_d;
      s1_first_q   <= s1_first_d;
      s1_last_q    <= s1_last_d;
      s1_inblk_q   <= s1_inblk_d;
      s1_diag_q    <= s1_diag_d;
      s1_waddr_q   <= s1_waddr_d;
      s2_valid_q   <= s1_valid_q && (state_q == ST_MUL);
      s2_first_q   <= s1_first_q;
      s2_last_q    <= s1_last_q;
      s2_waddr_q   <= s1_waddr_q;
    end
  end

  // Multiply then accumulate, one register between the two.
  always_ff @(posedge clk_i) begin
    prod_q <= lhs_data * sq_rdb;
    if (s2_valid_q) begin
      acc_q <= acc_sum;
    end
  end

  mpm_ram #(.DEPTH(CELLS), .AW(AW), .DW(DATA_W)) u_src (
    .clk_i, .we_i(src_we), .waddr_i(src_wa), .wdata_i(src_wd),
    .ra_addr_i(src_ra), .rb_addr_i(src_ra), .ra_data_o(src_rd), .rb_data_o()
  );

  mpm_ram #(.DEPTH(CELLS), .AW(AW), .DW(DATA_W)) u_res (
    .clk_i, .we_i(res_we), .waddr_i(res_wa), .wdata_i(res_wd),
    .ra_addr_i(res_ra), .rb_addr_i(res_ra), .ra_data_o(res_rd), .rb_data_o()
  );

  mpm_ram #(.DEPTH(CELLS), .AW(AW), .DW(DATA_W)) u_sq (
    .clk_i, .we_i(sq_we), .waddr_i(sq_wa), .wdata_i(sq_wd),
    .ra_addr_i(sq_ra), .rb_addr_i(sq_rb), .ra_data_o(sq_rda), .rb_data_o(sq_rdb)
  );

  mpm_ram #(.DEPTH(CELLS), .AW(AW), .DW(DATA_W)) u_tmp (
    .clk_i, .we_i(tmp_we), .waddr_i(tmp_wa), .wdata_i(tmp_wd),
    .ra_addr_i(tmp_ra), .rb_addr_i(tmp_ra), .ra_data_o(tmp_rd), .rb_data_o()
  );

  assign host_rdata_o = res_rd;
  assign idle_o       = state_q == ST_IDLE;

endmodule

### sv/matrix_power_mod_2_32.sv
`timescale 1ns / 1ps

// Matrix power modulo 2^32 by square-and-multiply.
// Command channel (in_valid_i / in_stall_o): write a source entry, start a
// power of the leading dim-by-dim block, read a result entry, or no-op.
// Result channel (out_valid_o / out_stall_i): one transfer per command with
// the echoed command in ack_kind_o and the entry in read_value_o for reads.
// Configuration channel (cfg_valid_i / cfg_ready_o): index 0 sets dim,
// index 1 sets circulant mode; write only while no command is in flight.
// Writes, reads and no-ops follow back to back while no result is stalled; the
// result register loads from the pending command once the engine is idle.
// A power command runs a setup pass, then for each bit of the exponent one or
// two products (only row zero is computed in circulant mode), each followed
// by a copy-back; setup and copy-back sweep all MAX_DIM^2 cells. All products
// share the single multiply-accumulate unit and single-write-port working stores.
// After reset a clearing pass over all MAX_DIM^2 cells zeroes the source and
// result stores; commands stall until it ends.
// A stalled result holds; one further command can wait behind it.

module matrix_power_mod_2_32
  import mpm_pkg::*;
#(
  parameter int unsigned MAX_DIM = MAX_DIM_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [CMD_W-1:0]     cmd_i,
  input  logic [POS_W-1:0]     row_i,
  input  logic [POS_W-1:0]     col_i,
  input  logic [DATA_W-1:0]    entry_value_i,
  input  logic [EXP_W-1:0]     exponent_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [DATA_W-1:0]    read_value_o,
  output logic [CMD_W-1:0]     ack_kind_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DIM_W-1:0]     cfg_data_i
);

  localparam int unsigned CELLS = MAX_DIM * MAX_DIM;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned IW    = $clog2(MAX_DIM);

  logic [DIM_W-1:0]  dim_q;
  logic              circ_q;
  logic              pend_q, pend_ok_q;
  logic [CMD_W-1:0]  pend_cmd_q;
  logic [AW-1:0]     pend_addr_q;
  logic              eng_idle, pend_go, accept, in_ok;
  logic [AW-1:0]     in_addr, host_raddr;
  logic [DATA_W-1:0] host_rdata;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q  <= DIM_RESET;
      circ_q <= 1'b0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_DIM) begin
        dim_q <= cfg_data_i;
      end else if (cfg_index_i == CFG_CIRC) begin
        circ_q <= cfg_data_i[0];
      end
    end
  end

  // Command transfer and entry address.
  assign in_ok      = (int'(row_i) < MAX_DIM) && (int'(col_i) < MAX_DIM);
  assign in_addr    = AW'(IW'(row_i)) * AW'(MAX_DIM) + AW'(IW'(col_i));
  assign pend_go    = eng_idle && (!out_valid_o || !out_stall_i);
  assign in_stall_o = !eng_idle || (pend_q && !pend_go);
  assign accept     = in_valid_i && !in_stall_o;
  assign host_raddr = accept ? in_addr : pend_addr_q;

  // One command waits here while its read data or power run completes or the result stalls.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else if (accept) begin
      pend_q <= 1'b1;
    end else if (pend_go) begin
      pend_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_cmd_q  <= cmd_i;
      pend_ok_q   <= in_ok;
      pend_addr_q <= in_addr;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (pend_q && pend_go) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_q && pend_go) begin
      ack_kind_o   <= pend_cmd_q;
      read_value_o <= (pend_cmd_q == CMD_READ && pend_ok_q) ? host_rdata : '0;
    end
  end

  mpm_engine #(.MAX_DIM(MAX_DIM)) u_engine (
    .clk_i,
    .rst_ni,
    .start_i      (accept && cmd_i == CMD_POWER),
    .exp_i        (exponent_i),
    .dim_i        (dim_q),
    .circ_i       (circ_q),
    .host_we_i    (accept && cmd_i == CMD_WRITE && in_ok),
    .host_waddr_i (in_addr),
    .host_wdata_i (entry_value_i),
    .host_raddr_i (host_raddr),
    .host_rdata_o (host_rdata),
    .idle_o       (eng_idle)
  );

endmodule

### sv/mpm_checker.sv
`timescale 1ns / 1ps

module mpm_checker
  import mpm_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic [CMD_W-1:0]  cmd_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [DATA_W-1:0] read_value_o,
  input logic [CMD_W-1:0]  ack_kind_o
);

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(read_value_o) && $stable(ack_kind_o))
    else $error("stalled result changed");

  // Only reads carry a nonzero value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ack_kind_o != CMD_READ |-> read_value_o == '0)
    else $error("nonzero value on a non-read result");

  // A power transfer blocks the next command while it runs.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && cmd_i == CMD_POWER |=> in_stall_o)
    else $error("command taken during a power run");

endmodule

bind matrix_power_mod_2_32 mpm_checker u_mpm_checker (.*);

### verif/tb_matrix_power_mod_2_32.sv
`timescale 1ns / 1ps

module tb_matrix_power_mod_2_32;
  import mpm_pkg::*;

  localparam int unsigned CELLS = MAX_DIM_DEF * MAX_DIM_DEF;
  localparam int unsigned CYCLE_LIMIT = 8000000;
  localparam int unsigned LONG_HOLD = 400;

  typedef bit [31:0] mat_t [CELLS];

  typedef struct {
    cmd_e      cmd;
    bit [3:0]  row;
    bit [3:0]  col;
    bit [31:0] value;
    bit [63:0] power;
  } mat_cmd_t;

  typedef struct {
    bit [31:0] read_value;
    bit [1:0]  ack_kind;
  } ack_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [CMD_W-1:0]     cmd_i = CMD_NOP;
  logic [POS_W-1:0]     row_i = '0;
  logic [POS_W-1:0]     col_i = '0;
  logic [DATA_W-1:0]    entry_value_i = '0;
  logic [EXP_W-1:0]     exponent_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [DATA_W-1:0]    read_value_o;
  logic [CMD_W-1:0]     ack_kind_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = CFG_DIM;
  logic [DIM_W-1:0]     cfg_data_i = '0;

  matrix_power_mod_2_32 dut (.*);

  // Predictor state.
  mat_t      source_mat;
  mat_t      result_mat;
  bit [4:0]  dim_reg = 5'd16;
  bit        circ_reg = 1'b0;

  mat_cmd_t  pending_cmds [$];
  ack_t      ack_expect_q [$];
  int unsigned accepted_cnt = 0;
  int unsigned mismatch_cnt = 0;
  bit        calm = 1'b0;

  // Clock.
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic int unsigned active_dim();
    if (dim_reg == 0) return 1;
    if (dim_reg > MAX_DIM_DEF) return MAX_DIM_DEF;
    return dim_reg;
  endfunction

  // One product modulo 2^32; circulant mode builds row zero and rotates it.
  function automatic mat_t mat_product(mat_t lhs, mat_t rhs, int unsigned n, bit circ);
    mat_t      prod;
    bit [31:0] acc;
    for (int i = 0; i < CELLS; i++) prod[i] = '0;
    if (circ) begin
      for (int j = 0; j < n; j++) begin
        acc = '0;
        for (int k = 0; k < n; k++) acc += lhs[k] * rhs[k * MAX_DIM_DEF + j];
        prod[j] = acc;
      end
      for (int i = 1; i < n; i++)
        for (int j = 0; j < n; j++)
          prod[i * MAX_DIM_DEF + j] = prod[(i - 1) * MAX_DIM_DEF + ((j + n - 1) % n)];
    end else begin
      for (int i = 0; i < n; i++)
        for (int j = 0; j < n; j++) begin
          acc = '0;
          for (int k = 0; k < n; k++)
            acc += lhs[i * MAX_DIM_DEF + k] * rhs[k * MAX_DIM_DEF + j];
          prod[i * MAX_DIM_DEF + j] = acc;
        end
    end
    return prod;
  endfunction

  // Square-and-multiply from the identity over the leading block.
  function automatic void raise_power(bit [63:0] e);
    int unsigned n;
    mat_t        sq;
    n = active_dim();
    for (int i = 0; i < CELLS; i++) begin
      result_mat[i] = '0;
      sq[i] = '0;
    end
    for (int i = 0; i < n; i++) begin
      result_mat[i * MAX_DIM_DEF + i] = 32'd1;
      for (int j = 0; j < n; j++) sq[i * MAX_DIM_DEF + j] = source_mat[i * MAX_DIM_DEF + j];
    end
    while (e != 0) begin
      if (e[0]) result_mat = mat_product(result_mat, sq, n, circ_reg);
      e >>= 1;
      sq = mat_product(sq, sq, n, circ_reg);
    end
  endfunction

  // Applies one accepted command and queues the acknowledge it causes.
  function automatic void predict_ack(mat_cmd_t c);
    ack_t a;
    a.read_value = '0;
    a.ack_kind = c.cmd;
    case (c.cmd)
      CMD_WRITE: source_mat[c.row * MAX_DIM_DEF + c.col] = c.value;
      CMD_POWER: raise_power(c.power);
      CMD_READ:  a.read_value = result_mat[c.row * MAX_DIM_DEF + c.col];
      default: ;
    endcase
    ack_expect_q.push_back(a);
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Command driver: presents queued commands, holds them while stalled.
  int unsigned send_gap = 0;
  mat_cmd_t    cur_cmd;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict_ack(cur_cmd);
        accepted_cnt++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          cur_cmd = pending_cmds.pop_front();
          cmd_i <= cur_cmd.cmd;
          row_i <= cur_cmd.row;
          col_i <= cur_cmd.col;
          entry_value_i <= cur_cmd.value;
          exponent_i <= cur_cmd.power;
          in_valid_i <= 1'b1;
          send_gap = pick_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result stall: random gaps, plus one long hold while commands keep coming.
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  always @(posedge clk_i) begin
    if (!hold_done && accepted_cnt >= 300) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      stall_left = pick_gap();
      out_stall_i <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // Result monitor: each transfer is checked against the oldest expectation.
  always @(posedge clk_i) begin
    ack_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (ack_expect_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("ERROR: unexpected result kind=%0d value=%h", ack_kind_o, read_value_o);
      end else begin
        want = ack_expect_q.pop_front();
        if (want.ack_kind !== ack_kind_o || want.read_value !== read_value_o) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("ERROR: result mismatch exp kind=%0d value=%h got kind=%0d value=%h",
                     want.ack_kind, want.read_value, ack_kind_o, read_value_o);
        end
      end
    end
  end

  // Run limit.
  int unsigned cycle_cnt = 0;
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic push_cmd(cmd_e c, int unsigned r, int unsigned cl, bit [31:0] v,
                          bit [63:0] e);
    mat_cmd_t m;
    m.cmd = c;
    m.row = 4'(r);
    m.col = 4'(cl);
    m.value = v;
    m.power = e;
    pending_cmds.push_back(m);
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending_cmds.size() > 0 || in_valid_i || ack_expect_q.size() > 0);
    repeat (5) @(posedge clk_i);
  endtask

  // One register write; the trailing wait with cfg_valid_i low keeps back-to-back writes apart.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, bit [4:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_DIM) dim_reg = val;
    else circ_reg = val[0];
    @(posedge clk_i);
  endtask

  function automatic int unsigned pick_pos(int unsigned n);
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 15);
    return $urandom_range(0, n - 1);
  endfunction

  // Exponents stay short on large blocks to bound the product count.
  function automatic bit [63:0] pick_power(int unsigned n);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (n > 8) return $urandom_range(0, 7);
    if (n <= 2 && r == 0) return {$urandom, $urandom};
    if (r < 3) return $urandom_range(0, 3);
    return $urandom_range(0, 1023);
  endfunction

  // Jobs of loads, one power and reads, with some stray commands mixed in.
  task automatic fill_phase(int unsigned count);
    int unsigned n;
    int unsigned made;
    int unsigned k;
    int unsigned start_size;
    n = active_dim();
    made = 0;
    if (n == 1) begin
      push_cmd(CMD_WRITE, 0, 0, 32'hFFFF_FFFF, '0);
      push_cmd(CMD_POWER, 0, 0, '0, 64'hFFFF_FFFF_FFFF_FFFF);
      push_cmd(CMD_READ, 0, 0, '0, '0);
      push_cmd(CMD_POWER, 0, 0, '0, 64'h8000_0000_0000_0000);
      push_cmd(CMD_READ, 0, 0, '0, '0);
      made = 5;
    end
    while (made < count) begin
      start_size = pending_cmds.size();
      k = $urandom_range(1, n * n < 12 ? n * n + 2 : 12);
      repeat (k) push_cmd(CMD_WRITE, pick_pos(n), pick_pos(n), $urandom, {$urandom, $urandom});
      if ($urandom_range(0, 4) == 0)
        push_cmd(cmd_e'($urandom_range(0, 3)), $urandom_range(0, 15), $urandom_range(0, 15),
                 $urandom, '0);
      push_cmd(CMD_POWER, $urandom_range(0, 15), $urandom_range(0, 15), $urandom,
               pick_power(n));
      k = $urandom_range(2, 10);
      repeat (k) push_cmd(CMD_READ, pick_pos(n), pick_pos(n), $urandom, '0);
      made = made + pending_cmds.size() - start_size;
    end
  endtask

  // Stimulus sequencing and end of run.
  initial begin
    bit [4:0] dims [11] = '{5'd16, 5'd1, 5'd2, 5'd0, 5'd31, 5'd17, 5'd5, 5'd3, 5'd8,
                            5'd16, 5'd4};
    bit       circs [11] = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1,
                             1'b1, 1'b0};
    for (int i = 0; i < CELLS; i++) begin
      source_mat[i] = '0;
      result_mat[i] = '0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed commands at the reset configuration.
    push_cmd(CMD_READ, 15, 15, '0, '0);
    push_cmd(CMD_NOP, 15, 15, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    push_cmd(CMD_WRITE, 0, 0, 32'h0, '0);
    push_cmd(CMD_WRITE, 15, 15, 32'hFFFF_FFFF, '0);
    push_cmd(CMD_WRITE, 0, 15, 32'h8000_0001, '0);
    push_cmd(CMD_WRITE, 15, 0, 32'h7FFF_FFFF, '0);
    push_cmd(CMD_POWER, 0, 0, '0, 64'd0);
    push_cmd(CMD_READ, 0, 0, '0, '0);
    push_cmd(CMD_READ, 15, 15, '0, '0);
    push_cmd(CMD_READ, 0, 15, '0, '0);
    push_cmd(CMD_POWER, 0, 0, '0, 64'd1);
    push_cmd(CMD_READ, 15, 15, '0, '0);
    push_cmd(CMD_READ, 0, 15, '0, '0);
    push_cmd(CMD_POWER, 0, 0, '0, 64'd2);
    push_cmd(CMD_READ, 15, 15, '0, '0);
    push_cmd(CMD_READ, 15, 0, '0, '0);
    push_cmd(CMD_NOP, 0, 0, '0, '0);
    wait_idle();

    // Several register settings; the sender pauses at each until all results are in.
    for (int p = 0; p < 11; p++) begin
      write_reg(CFG_DIM, dims[p]);
      write_reg(CFG_CIRC, circs[p]);
      calm = (p % 4 == 3);
      fill_phase(140);
      if (p == 4) begin
        // A power at dim 2 after powers at a large size, then a read outside its block.
        wait_idle();
        write_reg(CFG_DIM, 5'd2);
        push_cmd(CMD_POWER, 0, 0, '0, 64'd3);
        push_cmd(CMD_READ, 9, 9, '0, '0);
      end
      wait_idle();
    end

    repeat (20) @(posedge clk_i);
    if (mismatch_cnt == 0 && ack_expect_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
